/* rtl/rbd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and field widths of the ring buffer deque.
package rbd_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OPCODE_W  = 3;
    localparam int VALUE_W   = 32;
    localparam int INDEX_W   = 11;
    localparam int COUNT_W   = 11;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 112;

    typedef enum logic [OPCODE_W-1:0] {
        OP_QUERY      = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_POP_FRONT  = 3'd4,
        OP_READ       = 3'd5,
        OP_RESIZE     = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_SUMM,
        ST_LOAD
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic fill_step;
        logic summ;
        logic load;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic grow;
        logic fill_last;
    } sts_t;

endpackage

/* rtl/rbd_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine of the ring buffer deque.
module rbd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  rbd_pkg::sts_t sts,
    output rbd_pkg::cmd_t cmd
);
    import rbd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = sts.grow ? ST_FILL : ST_SUMM;
            end
            ST_FILL:
            begin
                if (sts.fill_last)
                begin
                    state_next = ST_SUMM;
                end
            end
            ST_SUMM:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        s_tready      = 1'b0;
        cmd.capture   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.exec      = (state_reg == ST_EXEC);
        cmd.fill_step = (state_reg == ST_FILL);
        cmd.summ      = (state_reg == ST_SUMM);
        cmd.load      = (state_reg == ST_LOAD) && out_free;
        s_tready      = (state_reg == ST_IDLE);
    end

    // Hold the result until taken; a fresh load may replace one taken in the same cycle
    always_comb
    begin
        priority if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/rbd_datapath.sv */
`timescale 1ns / 1ps
// Pointers, element store and result register of the ring buffer deque.
module rbd_datapath #(
    parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic signed [rbd_pkg::VALUE_W-1:0]  cfg_wdata,
    input  logic [rbd_pkg::OPCODE_W-1:0]        opcode,
    input  logic signed [rbd_pkg::VALUE_W-1:0]  value,
    input  logic signed [rbd_pkg::INDEX_W-1:0]  index,
    input  logic [rbd_pkg::COUNT_W-1:0]         new_count,
    input  rbd_pkg::cmd_t                       cmd,
    output rbd_pkg::sts_t                       sts,
    output rbd_pkg::status_t                    status,
    output logic signed [rbd_pkg::VALUE_W-1:0]  read_value,
    output logic signed [rbd_pkg::VALUE_W-1:0]  front_value,
    output logic signed [rbd_pkg::VALUE_W-1:0]  back_value,
    output logic [rbd_pkg::COUNT_W-1:0]         count,
    output logic                                is_empty
);
    import rbd_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;
    localparam int DX_W   = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    // Element store
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  rd_a_en;
    logic [ADDR_W-1:0]     rd_a_addr;
    logic [DATA_WIDTH-1:0] rd_a_q;
    logic                  rd_b_en;
    logic [ADDR_W-1:0]     rd_b_addr;
    logic [DATA_WIDTH-1:0] rd_b_q;

    // Control state
    logic [ADDR_W-1:0]        head_reg, head_next;
    logic [ADDR_W-1:0]        tail_reg, tail_next;
    logic [CNT_W-1:0]         held_reg, held_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic signed [VALUE_W-1:0] dflt_reg;

    // Item and per-item payload
    op_t                       op_reg;
    logic [DATA_WIDTH-1:0]     val_reg;
    logic signed [INDEX_W-1:0] idx_reg;
    logic [COUNT_W-1:0]        tgt_reg;
    status_t                   sts_reg, sts_next;
    logic [VALUE_W-1:0]        rd_reg, rd_next;
    logic                      rd_mem_reg, rd_mem_next;

    // Working signals
    logic [DX_W-1:0]          val_x;
    logic [DX_W-1:0]          qa_x;
    logic [DX_W-1:0]          qb_x;
    logic [DX_W-1:0]          rdq_x;
    logic [ADDR_W-1:0]        head_inc, head_dec, tail_inc, tail_dec;
    logic                     full, empty;
    logic [CMP_W-1:0]         tgt_c, held_c;
    logic signed [CMP_W-1:0]  idx_s, held_s, off_neg, off_s;
    logic                     idx_ok;
    logic [ADDR_W:0]          add_off, add_sum;
    logic [ADDR_W:0]          add_wrap;
    logic                     refuse, grow;

    assign val_x = DX_W'($unsigned(value));
    assign qa_x  = DX_W'(rd_a_q);
    assign qb_x  = DX_W'(rd_b_q);
    assign rdq_x = DX_W'(rd_a_q);

    assign head_inc = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign tail_inc = (tail_reg == ADDR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? ADDR_W'(DEPTH - 1) : tail_reg - 1'b1;

    assign full  = (held_reg == CNT_W'(DEPTH));
    assign empty = (held_reg == '0);

    assign tgt_c  = CMP_W'(tgt_reg);
    assign held_c = CMP_W'(held_reg);

    // Negative index counts back from the end
    assign idx_s   = CMP_W'(idx_reg);
    assign held_s  = signed'(held_c);
    assign off_neg = held_s + idx_s;
    assign off_s   = (idx_s >= 0) ? idx_s : off_neg;
    assign idx_ok  = (idx_s >= 0) ? (idx_s < held_s) : (off_neg >= 0);

    // Shared position adder, wrapped by one compare and subtract
    assign add_off  = (op_reg == OP_RESIZE) ? tgt_c[ADDR_W:0] : off_s[ADDR_W:0];
    assign add_sum  = {1'b0, head_reg} + add_off;
    assign add_wrap = (add_sum >= (ADDR_W + 1)'(DEPTH)) ?
                      add_sum - (ADDR_W + 1)'(DEPTH) : add_sum;

    assign refuse = (tgt_c > CMP_W'(DEPTH));
    assign grow   = (tgt_c > held_c);

    assign sts.grow      = (op_reg == OP_RESIZE) && !refuse && grow;
    assign sts.fill_last = (fill_reg == CNT_W'(1));

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        held_next   = held_reg;
        fill_next   = fill_reg;
        sts_next    = sts_reg;
        rd_next     = rd_reg;
        rd_mem_next = rd_mem_reg;
        mem_we      = 1'b0;
        mem_waddr   = tail_reg;
        mem_wdata   = val_reg;
        rd_a_en     = 1'b0;
        rd_a_addr   = head_reg;
        rd_b_en     = 1'b0;
        rd_b_addr   = tail_dec;

        if (cmd.exec)
        begin
            sts_next    = STS_OK;
            rd_next     = '0;
            rd_mem_next = 1'b0;
            unique case (op_reg)
                OP_QUERY:
                begin
                end
                OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        sts_next = STS_FULL;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = tail_reg;
                        tail_next = tail_inc;
                        held_next = held_reg + 1'b1;
                    end
                end
                OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        sts_next = STS_FULL;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = head_dec;
                        head_next = head_dec;
                        held_next = held_reg + 1'b1;
                    end
                end
                OP_POP_BACK:
                begin
                    if (empty)
                    begin
                        sts_next = STS_EMPTY;
                        rd_next  = dflt_reg;
                    end
                    else
                    begin
                        rd_a_en     = 1'b1;
                        rd_a_addr   = tail_dec;
                        rd_mem_next = 1'b1;
                        tail_next   = tail_dec;
                        held_next   = held_reg - 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        sts_next = STS_EMPTY;
                        rd_next  = dflt_reg;
                    end
                    else
                    begin
                        rd_a_en     = 1'b1;
                        rd_a_addr   = head_reg;
                        rd_mem_next = 1'b1;
                        head_next   = head_inc;
                        held_next   = held_reg - 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (idx_ok)
                    begin
                        rd_a_en     = 1'b1;
                        rd_a_addr   = add_wrap[ADDR_W-1:0];
                        rd_mem_next = 1'b1;
                    end
                    else
                    begin
                        sts_next = STS_EMPTY;
                        rd_next  = dflt_reg;
                    end
                end
                OP_RESIZE:
                begin
                    if (refuse)
                    begin
                        sts_next = STS_FULL;
                    end
                    else if (grow)
                    begin
                        fill_next = CNT_W'(tgt_c - held_c);
                    end
                    else
                    begin
                        held_next = tgt_c[CNT_W-1:0];
                        tail_next = add_wrap[ADDR_W-1:0];
                    end
                end
                OP_CLEAR:
                begin
                    head_next = '0;
                    tail_next = '0;
                    held_next = '0;
                end
            endcase
        end

        // Append the fill value one slot per cycle
        if (cmd.fill_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = tail_reg;
            tail_next = tail_inc;
            held_next = held_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end

        // Fetch the new ends; take the popped or read element from the last access
        if (cmd.summ)
        begin
            rd_a_en   = 1'b1;
            rd_a_addr = head_reg;
            rd_b_en   = 1'b1;
            rd_b_addr = tail_dec;
            if (rd_mem_reg)
            begin
                rd_next = rdq_x[VALUE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_a_en)
        begin
            rd_a_q <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_q <= mem[rd_b_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            held_reg <= '0;
            fill_reg <= '0;
            dflt_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            held_reg <= held_next;
            fill_reg <= fill_next;
            if (cfg_we)
            begin
                dflt_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op_t'(opcode);
            val_reg <= val_x[DATA_WIDTH-1:0];
            idx_reg <= index;
            tgt_reg <= new_count;
        end
        sts_reg    <= sts_next;
        rd_reg     <= rd_next;
        rd_mem_reg <= rd_mem_next;
        if (cmd.load)
        begin
            status      <= sts_reg;
            read_value  <= rd_reg;
            front_value <= empty ? dflt_reg : qa_x[VALUE_W-1:0];
            back_value  <= empty ? dflt_reg : qb_x[VALUE_W-1:0];
            count       <= held_c[COUNT_W-1:0];
            is_empty    <= empty;
        end
    end

endmodule

/* rtl/ring_buffer_deque.sv */
`timescale 1ns / 1ps
// Top level of the ring buffer deque: stream ports, controller and datapath.
//
// A double-ended queue of DEPTH elements held in a circular store, driven by one
// command item per input and answering with one result item each. Every item
// passes through accept, execute, read of the new front and back, and load, in that
// order. Its result is loaded into the output register in the load step, after the
// execute and read steps, because each store access has a registered read and the
// front and back are fetched after the operation has settled. A growing resize adds
// a fill step after execute that writes one slot per cycle, since the store takes
// one write a cycle. The result sits in an output register, so the next item is
// taken while a result still waits; that item then holds in its load step until the
// waiting result is taken. Reads of the default value register need no warm-up:
// the store has no clearing pass, and only slots holding elements reach the result.
module ring_buffer_deque #(
    parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rbd_pkg::VALUE_W-1:0]         cfg_wdata,    // default_value
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rbd_pkg::S_TDATA_W-1:0]       s_tdata,      // value, index, new_count
    input  logic [rbd_pkg::OPCODE_W-1:0]        s_tuser,      // opcode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rbd_pkg::M_TDATA_W-1:0]       m_tdata,      // read, front, back, count, empty
    output logic [rbd_pkg::STATUS_W-1:0]        m_tuser       // status
);
    import rbd_pkg::*;

    cmd_t                      cmd;
    sts_t                      sts;
    status_t                   res_status;
    logic signed [VALUE_W-1:0] res_read;
    logic signed [VALUE_W-1:0] res_front;
    logic signed [VALUE_W-1:0] res_back;
    logic [COUNT_W-1:0]        res_count;
    logic                      res_empty;

    rbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rbd_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (signed'(cfg_wdata)),
        .opcode      (s_tuser),
        .value       (signed'(s_tdata[VALUE_W-1:0])),
        .index       (signed'(s_tdata[VALUE_W+INDEX_W-1:VALUE_W])),
        .new_count   (s_tdata[VALUE_W+INDEX_W+COUNT_W-1:VALUE_W+INDEX_W]),
        .cmd         (cmd),
        .sts         (sts),
        .status      (res_status),
        .read_value  (res_read),
        .front_value (res_front),
        .back_value  (res_back),
        .count       (res_count),
        .is_empty    (res_empty)
    );

    assign m_tdata = {4'b0000, res_empty, res_count, res_back, res_front, res_read};
    assign m_tuser = res_status;

endmodule
